// ===== src/fixed_point_q14_18_alu_unit_macros.svh =====
// assertion macros for the q14.18 alu
// no dependencies
`ifndef FIXED_POINT_Q14_18_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_Q14_18_ALU_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FXA_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define FXA_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define FXA_ASSERT_IMP(label, clk, rst_n, a, c)
`define FXA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/fxa_pkg.sv =====
// shared constants, commands and stage types for the q14.18 alu
// no dependencies
`default_nettype none
package fxa_pkg;
	localparam int WordBits = 32;
	localparam int IntBits  = 14;
	localparam int FracBits = WordBits - IntBits;
	localparam int NumBits  = WordBits + FracBits;
	localparam int CntBits  = $clog2(NumBits + 1);
	localparam int DivSteps = 4;
	localparam int DivStages = (NumBits + DivSteps - 1) / DivSteps;
	localparam int Latency  = DivStages + 2;

	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_MUL   = 3'd0;
	localparam cmd_t CMD_DIV   = 3'd1;
	localparam cmd_t CMD_ABS   = 3'd2;
	localparam cmd_t CMD_FRAC  = 3'd3;
	localparam cmd_t CMD_FLOOR = 3'd4;
	localparam cmd_t CMD_CEIL  = 3'd5;
	localparam cmd_t CMD_ROUND = 3'd6;
	localparam cmd_t CMD_RSVD  = 3'd7;

	// control riding along the divider
	typedef struct packed {
		logic                valid;
		logic                is_div;
		logic                neg;
		logic                dz;
		logic [WordBits-1:0] simple;
	} ctl_t;
endpackage
`default_nettype wire

// ===== src/fxa_div.sv =====
// radix-2 restoring divider pipeline, DivSteps quotient bits per stage
// depends on fxa_pkg and the macros header
`default_nettype none
`include "fixed_point_q14_18_alu_unit_macros.svh"
module fxa_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fxa_pkg::ctl_t                  ctl_in,
	input  wire logic [fxa_pkg::NumBits-1:0]    num_in,
	input  wire logic [fxa_pkg::WordBits-1:0]   den_in,
	output fxa_pkg::ctl_t                       ctl_out,
	output logic [fxa_pkg::NumBits-1:0]         quo_out
);
	localparam int N = fxa_pkg::NumBits;
	localparam int W = fxa_pkg::WordBits;
	localparam int S = fxa_pkg::DivStages;
	localparam int K = fxa_pkg::DivSteps;

	fxa_pkg::ctl_t  ctl_s [S];
	logic [N-1:0]   num_s [S];
	logic [W:0]     rem_s [S];
	logic [W-1:0]   den_s [S];

	for (genvar g = 0; g < S; g++) begin : g_stage
		fxa_pkg::ctl_t c_in;
		logic [N-1:0]  n_in;
		logic [W:0]    r_in;
		logic [W-1:0]  d_in;
		logic [N-1:0]  n_c;
		logic [W:0]    r_c;
		if (g == 0) begin : g_head
			assign c_in = ctl_in;
			assign n_in = num_in;
			assign r_in = '0;
			assign d_in = den_in;
		end else begin : g_tail
			assign c_in = ctl_s[g-1];
			assign n_in = num_s[g-1];
			assign r_in = rem_s[g-1];
			assign d_in = den_s[g-1];
		end
		always_comb begin
			logic [W+1:0] t;
			t = '0;
			n_c = n_in;
			r_c = r_in;
			for (int i = 0; i < K; i++) begin
				// last stage runs short when the numerator width is not a multiple of K
				if (g * K + i < N) begin
					t = {r_c, n_c[N-1]};
					n_c = {n_c[N-2:0], 1'b0};
					if (t >= {2'b00, d_in}) begin
						t = t - {2'b00, d_in};
						n_c[0] = 1'b1;
					end
					r_c = t[W:0];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else begin
				ctl_s[g] <= c_in;
			end
		end
		always_ff @(posedge clk) begin
			num_s[g] <= n_c;
			rem_s[g] <= r_c;
			den_s[g] <= d_in;
		end
	end

	assign ctl_out = ctl_s[S-1];
	assign quo_out = num_s[S-1];

	`FXA_ASSERT_NXT(a_valid_moves, clk, arst_n, ctl_in.valid, ctl_s[0].valid)
	`FXA_ASSERT_NXT(a_idle_moves, clk, arst_n, !ctl_in.valid, !ctl_s[0].valid)
	`FXA_ASSERT_IMP(a_rem_bound, clk, arst_n, ctl_s[0].valid && den_s[0] != '0,
		rem_s[0] < {1'b0, den_s[0]})
endmodule
`default_nettype wire

// ===== src/fixed_point_q14_18_alu_unit.sv =====
// Q14.18 fixed-point alu: mul, div, abs, frac, floor, ceil, round.
// Takes one beat per cycle (busy is always low); done marks the result for one
// cycle. A beat passes through an input stage (operand magnitudes, multiply,
// simple ops), the divider pipeline of 13 stages, 4 quotient bits each (2 in
// the last), and an output stage (sign fix and selection). Results cannot be
// stalled.
// depends on fxa_pkg, fxa_div and the macros header
`default_nettype none
`include "fixed_point_q14_18_alu_unit_macros.svh"
module fixed_point_q14_18_alu_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         command,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output logic                    done,
	output logic signed [31:0]      result,
	output logic                    divide_by_zero
);
	localparam int W = fxa_pkg::WordBits;
	localparam int F = fxa_pkg::FracBits;
	localparam int N = fxa_pkg::NumBits;

	logic [W-1:0] mag_a, mag_b, simple_c, flo;
	logic [F-1:0] frac_a;
	logic signed [2*W-1:0] prod;
	fxa_pkg::ctl_t ctl_c, ctl_d, ctl_s1;
	logic [N-1:0] num_c, quo;
	logic [W-1:0] den_s1;
	logic [N-1:0] num_s1;
	logic [W-1:0] out_c;

	assign busy = 1'b0;

	always_comb begin
		mag_a  = operand_a[W-1] ? W'(-operand_a) : operand_a;
		mag_b  = operand_b[W-1] ? W'(-operand_b) : operand_b;
		frac_a = operand_a[F-1:0];
		flo    = {operand_a[W-1:F], {F{1'b0}}};
		prod   = operand_a * operand_b;
		num_c  = {mag_a, {F{1'b0}}};
		case (command)
			fxa_pkg::CMD_MUL:   simple_c = prod[F+W-1:F];
			fxa_pkg::CMD_ABS:   simple_c = mag_a;
			fxa_pkg::CMD_FRAC:  simple_c = {{(W-F){1'b0}}, mag_a[F-1:0]};
			fxa_pkg::CMD_FLOOR: simple_c = flo;
			fxa_pkg::CMD_CEIL:  simple_c = flo + ((frac_a != '0) ? W'(1) << F : '0);
			fxa_pkg::CMD_ROUND: begin
				simple_c = {mag_a[W-1:F], {F{1'b0}}} + (mag_a[F-1] ? W'(1) << F : '0);
				if (operand_a[W-1]) simple_c = -simple_c;
			end
			default:            simple_c = '0;
		endcase
		ctl_c.valid  = start;
		ctl_c.is_div = (command == fxa_pkg::CMD_DIV);
		ctl_c.neg    = operand_a[W-1] ^ operand_b[W-1];
		ctl_c.dz     = (command == fxa_pkg::CMD_DIV) && (operand_b == '0);
		ctl_c.simple = simple_c;
	end

	// input stage; the scaled product rides in the simple field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
		end
	end
	always_ff @(posedge clk) begin
		num_s1 <= num_c;
		den_s1 <= mag_b;
	end

	fxa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.num_in  (num_s1),
		.den_in  (den_s1),
		.ctl_out (ctl_d),
		.quo_out (quo)
	);

	always_comb begin
		if (ctl_d.dz) begin
			out_c = '0;
		end else if (ctl_d.is_div) begin
			out_c = ctl_d.neg ? W'(-quo) : quo[W-1:0];
		end else begin
			out_c = ctl_d.simple;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_d.valid;
		end
	end
	always_ff @(posedge clk) begin
		result         <= out_c;
		divide_by_zero <= ctl_d.dz;
	end

	`FXA_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`FXA_ASSERT_IMP(a_dz_only_div, clk, arst_n, ctl_d.valid && ctl_d.dz, ctl_d.is_div)
	`FXA_ASSERT_NXT(a_done_follows, clk, arst_n, ctl_d.valid, done)
	`FXA_ASSERT_NXT(a_dz_zero, clk, arst_n, ctl_d.valid && ctl_d.dz,
		done && divide_by_zero && result == '0)
endmodule
`default_nettype wire
